[src/sab_pkg.sv]
package sab_pkg;

  localparam int REG_BITS   = 12;
  localparam int CHAN_BITS  = 8;
  localparam int ADDR_BITS  = 22;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_POS_X         = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POS_Y         = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam logic [CHAN_BITS-1:0] OPAQUE = 8'd255;

  typedef struct packed {
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] red;
  } rgb_t;

  // Exact x / 255 for any x up to 255 * 255: add the high byte back in, round, keep the high byte.
  function automatic logic [CHAN_BITS-1:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

[src/sab_blend.sv]
module sab_blend (
  input  sab_pkg::rgb_t                 tex,
  input  sab_pkg::rgb_t                 dst,
  input  logic [sab_pkg::CHAN_BITS-1:0] alpha,
  output sab_pkg::rgb_t                 mix
);

  logic [sab_pkg::CHAN_BITS-1:0] inv_alpha;

  // The weighted sum never exceeds 255 * 255, so it fits in 16 bits.
  function automatic logic [sab_pkg::CHAN_BITS-1:0] blend_ch(
    input logic [7:0] t,
    input logic [7:0] d,
    input logic [7:0] a,
    input logic [7:0] ia
  );
    logic [15:0] sum;
    sum = 16'(t) * 16'(a) + 16'(d) * 16'(ia);
    return sab_pkg::div255(sum);
  endfunction

  assign inv_alpha = sab_pkg::OPAQUE - alpha;

  always_comb begin
    mix.red   = blend_ch(tex.red,   dst.red,   alpha, inv_alpha);
    mix.green = blend_ch(tex.green, dst.green, alpha, inv_alpha);
    mix.blue  = blend_ch(tex.blue,  dst.blue,  alpha, inv_alpha);
  end

endmodule

[src/sprite_alpha_blit.sv]
// Channel   Dir  Signals                                   Content
// s_*       in   s_tvalid s_tready s_tdata[55:0]            one texel with the screen color under it
// m_*       out  m_tvalid m_tready m_tdata[47:0] m_tuser    one pixel write, m_tlast ends the sprite
//                m_tlast
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data     register writes, always ready
//
// One texel per cycle unless the output stalls: the texel is placed and clipped into the input
// register, then the address multiply and the per-channel blend feed the output register.
// A beat is accepted while a finished pixel waits, as long as the input register can move on.
// rst is synchronous: counters go to zero, position to 0, all sizes to 1.
// A stalled output holds its beat; the input side stalls only once both stages are full.
module sprite_alpha_blit #(
  parameter int COORD_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: tex_red, tex_green, tex_blue, tex_alpha, dst_red, dst_green, dst_blue
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  // m_tdata: pixel_address[21:0], out_red, out_green, out_blue, 2 bits zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // m_tuser: write_enable
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sab_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [sab_pkg::REG_BITS-1:0]     cfg_data
);

  localparam int PW   = ((COORD_BITS > sab_pkg::REG_BITS) ? COORD_BITS : sab_pkg::REG_BITS) + 2;
  localparam int CMPW = ((COORD_BITS + 1 > sab_pkg::REG_BITS) ? COORD_BITS + 1
                                                               : sab_pkg::REG_BITS) + 1;
  localparam logic [CMPW-1:0] SIZE_LIM = CMPW'(1) << COORD_BITS;
  localparam int RB = sab_pkg::REG_BITS;

  // Configuration
  logic signed [RB-1:0] pos_x;
  logic signed [RB-1:0] pos_y;
  logic [RB-1:0] sprite_width;
  logic [RB-1:0] sprite_height;
  logic [RB-1:0] screen_width;
  logic [RB-1:0] screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      sprite_width  <= RB'(1);
      sprite_height <= RB'(1);
      screen_width  <= RB'(1);
      screen_height <= RB'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sab_pkg::REG_POS_X:         pos_x         <= cfg_data;
        sab_pkg::REG_POS_Y:         pos_y         <= cfg_data;
        sab_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
        sab_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data;
        sab_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        sab_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Placement and clipping, ahead of the input register
  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] column_count_next;
  logic [COORD_BITS-1:0] row_count_next;
  logic [CMPW-1:0] sw_raw, sh_raw, sw_eff, sh_eff;
  logic signed [PW-1:0] x_pos, y_pos;
  logic [PW-1:0] scw_ext, sch_ext;
  logic in_on, row_end, in_last, in_accept;

  always_comb begin
    sw_raw = CMPW'(sprite_width);
    sh_raw = CMPW'(sprite_height);
    if (sw_raw == '0) sw_eff = CMPW'(1);
    else if (sw_raw > SIZE_LIM) sw_eff = SIZE_LIM;
    else sw_eff = sw_raw;
    if (sh_raw == '0) sh_eff = CMPW'(1);
    else if (sh_raw > SIZE_LIM) sh_eff = SIZE_LIM;
    else sh_eff = sh_raw;

    x_pos = PW'(pos_x) + $signed({{(PW-COORD_BITS){1'b0}}, column_count});
    y_pos = PW'(pos_y) + $signed({{(PW-COORD_BITS){1'b0}}, row_count});
    scw_ext = PW'(screen_width);
    sch_ext = PW'(screen_height);
    in_on = !x_pos[PW-1] && !y_pos[PW-1] &&
            (PW'(x_pos) < scw_ext) && (PW'(y_pos) < sch_ext);

    row_end = (CMPW'(column_count) + CMPW'(1)) >= sw_eff;
    in_last = row_end && ((CMPW'(row_count) + CMPW'(1)) >= sh_eff);

    if (in_last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_count + COORD_BITS'(1);
    end else begin
      column_count_next = column_count + COORD_BITS'(1);
      row_count_next    = row_count;
    end
  end

  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Input register
  logic s1_valid, s1_on, s1_last, s1_move;
  logic [RB-1:0] s1_x, s1_y;
  logic [sab_pkg::CHAN_BITS-1:0] s1_alpha;
  sab_pkg::rgb_t s1_tex, s1_dst;
  logic out_valid;

  assign s1_move  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_on        <= in_on;
      s1_last      <= in_last;
      s1_x         <= RB'(x_pos);
      s1_y         <= RB'(y_pos);
      s1_tex.red   <= s_tdata[7:0];
      s1_tex.green <= s_tdata[15:8];
      s1_tex.blue  <= s_tdata[23:16];
      s1_alpha     <= s_tdata[31:24];
      s1_dst.red   <= s_tdata[39:32];
      s1_dst.green <= s_tdata[47:40];
      s1_dst.blue  <= s_tdata[55:48];
    end
  end

  // Address and blend, ahead of the output register
  sab_pkg::rgb_t mix;
  logic [2*RB-1:0] addr_full;
  logic [sab_pkg::ADDR_BITS-1:0] addr_next;

  sab_blend u_blend (
    .tex   (s1_tex),
    .dst   (s1_dst),
    .alpha (s1_alpha),
    .mix   (mix)
  );

  always_comb begin
    addr_full = (2*RB)'(s1_y) * (2*RB)'(screen_width) + (2*RB)'(s1_x);
    addr_next = addr_full[sab_pkg::ADDR_BITS-1:0];
  end

  // Output register
  logic [sab_pkg::ADDR_BITS-1:0] out_addr;
  sab_pkg::rgb_t out_rgb;
  logic out_we, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_addr <= s1_on ? addr_next : '0;
      out_rgb  <= s1_on ? mix : '0;
      out_we   <= s1_on && (s1_alpha != '0);
      out_last <= s1_last;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {2'b00, out_rgb.blue, out_rgb.green, out_rgb.red, out_addr};
  assign m_tuser[0] = out_we;
  assign m_tlast    = out_last;

  // Checks
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_last |=> column_count == '0 && row_count == '0)
    else $error("counters not cleared after last texel");

  a_column_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && !row_end |=> column_count == $past(column_count) + COORD_BITS'(1))
    else $error("column counter did not step");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty output register");

  a_offscreen_zero: assert property (@(posedge clk) disable iff (rst)
    s1_move && !s1_on |=> m_tdata == '0 && !m_tuser[0])
    else $error("off-screen texel produced a write");

endmodule

[tb/sv/sprite_alpha_blit_chk.sv]
`timescale 1ns / 1ps

// Watches the texel, pixel and register channels of the blitter, keeps its own
// placement counters and register copies, and checks every pixel beat in order.
module sprite_alpha_blit_chk #(
  parameter int COORD_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [55:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [47:0]                     m_tdata,
  input  logic [0:0]                      m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sab_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [sab_pkg::REG_BITS-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              pixels_seen,
  output int                              sprites_done,
  output int                              clipped_seen,
  output int                              written_seen
);

  typedef struct packed {
    logic [sab_pkg::ADDR_BITS-1:0] addr;
    logic [sab_pkg::CHAN_BITS-1:0] red;
    logic [sab_pkg::CHAN_BITS-1:0] green;
    logic [sab_pkg::CHAN_BITS-1:0] blue;
    logic                          we;
    logic                          last;
  } pixel_t;

  logic [sab_pkg::REG_BITS-1:0] pos_x_r, pos_y_r, spr_w_r, spr_h_r, scr_w_r, scr_h_r;
  logic [COORD_BITS-1:0]        col_cnt, row_cnt;
  pixel_t                       pixel_q[$];

  // A zero size acts as one, anything past the counter range acts as its full span.
  function automatic int sprite_span(input logic [sab_pkg::REG_BITS-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > (1 << COORD_BITS)) return 1 << COORD_BITS;
    return int'(v);
  endfunction

  function automatic logic [sab_pkg::CHAN_BITS-1:0] mix_channel(
    input logic [sab_pkg::CHAN_BITS-1:0] t,
    input logic [sab_pkg::CHAN_BITS-1:0] d,
    input logic [sab_pkg::CHAN_BITS-1:0] a
  );
    int acc;
    acc = int'(t) * int'(a) + int'(d) * (255 - int'(a));
    acc = acc / 255;
    return acc[sab_pkg::CHAN_BITS-1:0];
  endfunction

  // Places one texel, works out the pixel write it causes and steps the counters.
  function automatic pixel_t blit_texel(input logic [55:0] d);
    logic [sab_pkg::CHAN_BITS-1:0] tr, tg, tb, ta, dr, dg, db;
    int     px, py, x, y, lin;
    logic   on_screen, row_end, last;
    pixel_t p;
    tr = d[7:0];   tg = d[15:8];  tb = d[23:16]; ta = d[31:24];
    dr = d[39:32]; dg = d[47:40]; db = d[55:48];
    px = $signed(pos_x_r);
    py = $signed(pos_y_r);
    x = px + int'(col_cnt);
    y = py + int'(row_cnt);
    on_screen = (x >= 0) && (y >= 0) && (x < int'(scr_w_r)) && (y < int'(scr_h_r));
    row_end = int'(col_cnt) + 1 >= sprite_span(spr_w_r);
    last = row_end && (int'(row_cnt) + 1 >= sprite_span(spr_h_r));
    p = '0;
    if (on_screen) begin
      lin = y * int'(scr_w_r) + x;
      p.addr = lin[sab_pkg::ADDR_BITS-1:0];
      if (ta == sab_pkg::OPAQUE) begin
        p.red = tr; p.green = tg; p.blue = tb;
      end else if (ta == '0) begin
        p.red = dr; p.green = dg; p.blue = db;
      end else begin
        p.red = mix_channel(tr, dr, ta);
        p.green = mix_channel(tg, dg, ta);
        p.blue = mix_channel(tb, db, ta);
      end
      p.we = (ta != '0);
      if (p.we) written_seen++;
    end else begin
      clipped_seen++;
    end
    p.last = last;
    if (last) begin
      col_cnt = '0;
      row_cnt = '0;
    end else if (row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return p;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pos_x_r = '0;
      pos_y_r = '0;
      spr_w_r = 1;
      spr_h_r = 1;
      scr_w_r = 1;
      scr_h_r = 1;
      col_cnt = '0;
      row_cnt = '0;
      pixel_q.delete();
      fail_count = 0;
      pixels_seen = 0;
      sprites_done = 0;
      clipped_seen = 0;
      written_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sab_pkg::REG_POS_X:         pos_x_r = cfg_data;
          sab_pkg::REG_POS_Y:         pos_y_r = cfg_data;
          sab_pkg::REG_SPRITE_WIDTH:  spr_w_r = cfg_data;
          sab_pkg::REG_SPRITE_HEIGHT: spr_h_r = cfg_data;
          sab_pkg::REG_SCREEN_WIDTH:  scr_w_r = cfg_data;
          sab_pkg::REG_SCREEN_HEIGHT: scr_h_r = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pixel_q.push_back(blit_texel(s_tdata));
      if (m_tvalid && m_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $error("pixel beat with no texel behind it: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (want.last) sprites_done++;
          check_field("pixel_address", want.addr, m_tdata[21:0]);
          check_field("out_red", want.red, m_tdata[29:22]);
          check_field("out_green", want.green, m_tdata[37:30]);
          check_field("out_blue", want.blue, m_tdata[45:38]);
          check_field("write_enable", want.we, m_tuser[0]);
          check_field("last_texel", want.last, m_tlast);
        end
      end
    end
    pending = pixel_q.size();
  end

endmodule

[tb/sv/sprite_alpha_blit_tb.sv]
`timescale 1ns / 1ps

module sprite_alpha_blit_tb;

  localparam int COORD_BITS    = 11;
  localparam int LIMIT         = 2_000_000;
  localparam int RANDOM_TEXELS = 1900;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [sab_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [sab_pkg::REG_BITS-1:0]     cfg_data = '0;

  int fail_count, pending, pixels_seen, sprites_done, clipped_seen, written_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int settings_used = 0;
  int texels_sent = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  sprite_alpha_blit #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sprite_alpha_blit_chk #(.COORD_BITS(COORD_BITS)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .pixels_seen(pixels_seen),
    .sprites_done(sprites_done), .clipped_seen(clipped_seen),
    .written_seen(written_seen)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles with %0d pixels outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int hold_len();
    int r;
    r = $urandom_range(1, 100);
    if (r <= 70) return $urandom_range(1, 3);
    if (r <= 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(1, 100) <= stall_pct) stall_left = hold_len();
    m_tready <= (stall_left == 0);
  end

  function automatic logic [55:0] pack_texel(input logic [7:0] tr, input logic [7:0] tg,
                                             input logic [7:0] tb, input logic [7:0] ta,
                                             input logic [7:0] dr, input logic [7:0] dg,
                                             input logic [7:0] db);
    return {db, dg, dr, ta, tb, tg, tr};
  endfunction

  // Opaque and fully transparent texels get extra weight.
  function automatic logic [55:0] random_texel();
    logic [7:0] a;
    int         r;
    r = $urandom_range(1, 100);
    if (r <= 20) a = sab_pkg::OPAQUE;
    else if (r <= 40) a = '0;
    else a = 8'($urandom_range(0, 255));
    return pack_texel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), a, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // Every call starts and ends at a clock edge; tvalid stays up between back-to-back beats.
  task automatic send_texel(input logic [55:0] d);
    int gap;
    gap = ($urandom_range(1, 100) <= send_idle_pct) ? hold_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    texels_sent++;
  endtask

  task automatic write_reg(input logic [sab_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [sab_pkg::REG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int px, input int py, input int sw, input int sh,
                              input int scw, input int sch);
    write_reg(sab_pkg::REG_POS_X, px[sab_pkg::REG_BITS-1:0]);
    write_reg(sab_pkg::REG_POS_Y, py[sab_pkg::REG_BITS-1:0]);
    write_reg(sab_pkg::REG_SPRITE_WIDTH, sw[sab_pkg::REG_BITS-1:0]);
    write_reg(sab_pkg::REG_SPRITE_HEIGHT, sh[sab_pkg::REG_BITS-1:0]);
    write_reg(sab_pkg::REG_SCREEN_WIDTH, scw[sab_pkg::REG_BITS-1:0]);
    write_reg(sab_pkg::REG_SCREEN_HEIGHT, sch[sab_pkg::REG_BITS-1:0]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // The first edge lets the checker take in the last texel before its count is trusted.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_sprite_dim();
    int r;
    r = $urandom_range(1, 100);
    if (r <= 5) return 0;
    if (r <= 8) return $urandom_range(2049, 4095);
    if (r <= 20) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_screen_dim();
    int r;
    r = $urandom_range(1, 100);
    if (r <= 5) return 0;
    if (r <= 40) return $urandom_range(1, 16);
    return $urandom_range(1, 4095);
  endfunction

  // Usually a place where the sprite overlaps the screen or hangs over an edge.
  function automatic int pick_pos(input int screen, input int sprite);
    int lo, hi;
    if ($urandom_range(1, 100) <= 25) return int'($urandom_range(0, 4095)) - 2048;
    lo = -((sprite == 0) ? 1 : ((sprite > 2048) ? 2048 : sprite));
    hi = (screen > 2047) ? 2047 : screen;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_idle_pct();
    if ($urandom_range(1, 5) == 1) return 0;
    return $urandom_range(5, 40);
  endfunction

  task automatic random_phase();
    int sw, sh, scw, sch, area, n;
    sw = pick_sprite_dim();
    sh = pick_sprite_dim();
    scw = pick_screen_dim();
    sch = pick_screen_dim();
    area = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
    if (area <= 48 && $urandom_range(1, 100) <= 75) n = area;
    else n = $urandom_range(1, 24);
    send_idle_pct = pick_idle_pct();
    stall_pct = pick_idle_pct();
    program_regs(pick_pos(scw, sw), pick_pos(sch, sh), sw, sh, scw, sch);
    repeat (n) send_texel(random_texel());
    drain();
  endtask

  initial begin
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset values: copy, keep, and blends at the alpha extremes.
    send_texel(pack_texel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_texel(pack_texel(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_texel(pack_texel(8'hFF, 8'h00, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h80));
    send_texel(pack_texel(8'hC8, 8'h37, 8'hFF, 8'h01, 8'h10, 8'hF0, 8'h00));
    send_texel(pack_texel(8'h01, 8'hFE, 8'h7F, 8'hFE, 8'hFF, 8'h00, 8'h80));
    drain();
    // Off the left edge, then zero sprite sizes and a zero screen width.
    program_regs(-1, 0, 1, 1, 1, 1);
    send_texel(pack_texel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56));
    drain();
    program_regs(0, 0, 0, 0, 0, 1);
    send_texel(pack_texel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56));
    drain();
    // Partly clipped sprite hanging over the left and bottom edges.
    program_regs(-1, 1, 3, 2, 2, 2);
    repeat (6) send_texel(random_texel());
    drain();
    // Oversized width, then shrunk under the running column count.
    program_regs(0, 0, 4095, 2, 8, 8);
    repeat (2) send_texel(random_texel());
    drain();
    program_regs(0, 0, 1, 2, 8, 8);
    repeat (2) send_texel(random_texel());
    drain();
    // Highest address, and one that wraps.
    program_regs(2047, 2047, 1, 1, 2048, 2048);
    send_texel(pack_texel(8'hAA, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    drain();
    program_regs(2047, 2047, 1, 1, 4095, 4095);
    send_texel(pack_texel(8'h55, 8'hAA, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
    drain();

    start = texels_sent;
    while (texels_sent - start < RANDOM_TEXELS) begin
      random_phase();
    end
    drain();

    $display("%0d texels under %0d register settings, %0d sprites finished",
             texels_sent, settings_used, sprites_done);
    $display("%0d pixels blended or copied, %0d clipped, %0d left as they were",
             written_seen, clipped_seen, pixels_seen - written_seen - clipped_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/sab_pkg.sv
src/sab_blend.sv
src/sprite_alpha_blit.sv
tb/sv/sprite_alpha_blit_chk.sv
tb/sv/sprite_alpha_blit_tb.sv
